@@ hw/rtl/lattice_random_walk_pcg32_macros.svh @@
// ----------------------------------------------------------------------------
// lattice_random_walk_pcg32_macros.svh
// Assertion macros shared by the lattice walk checker.
// ----------------------------------------------------------------------------
`ifndef LATTICE_RANDOM_WALK_PCG32_MACROS_SVH
`define LATTICE_RANDOM_WALK_PCG32_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define LRW_ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lattice walk assertion failed");

// Antecedent in this cycle, consequent in the next one.
`define LRW_ASSERT_NEXT(lbl, ante, cons) \
    `LRW_ASSERT_CLK(lbl, (ante) |=> (cons))

`endif

@@ hw/rtl/lrw_pkg.sv @@
// ----------------------------------------------------------------------------
// lrw_pkg
// Shared types and constants of the lattice random walk generator.
// ----------------------------------------------------------------------------
package lrw_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int WORD_WIDTH  = 32;
    localparam int STATE_WIDTH = 64;
    localparam int TIME_WIDTH  = 31;

    localparam logic [STATE_WIDTH-1:0] LCG_MULT = 64'd6364136223846793005;
    localparam logic [WORD_WIDTH-1:0]  LCG_MULT_LO = LCG_MULT[31:0];
    localparam logic [WORD_WIDTH-1:0]  LCG_MULT_HI = LCG_MULT[63:32];
    localparam logic [TIME_WIDTH-1:0]  TIME_MAX = {TIME_WIDTH{1'b1}};
    localparam logic [TIME_WIDTH-1:0]  TARGET_RESET = TIME_WIDTH'(1);

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [1:0] {
        DIR_POS_X = 2'd0,
        DIR_NEG_X = 2'd1,
        DIR_POS_Y = 2'd2,
        DIR_NEG_Y = 2'd3
    } lrw_dir_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_ADD,
        ST_EMIT
    } lrw_state_t;

    typedef struct packed {
        logic load_seed;
        logic mul;
        logic acc;
        logic add_seed;
        logic out_load;
        logic step;
    } lrw_cmd_t;

    typedef struct packed {
        logic out_free;
    } lrw_status_t;

endpackage

@@ hw/rtl/lrw_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrw_ctrl
// Sequencer for seeding and stepping the walk generator.
// ----------------------------------------------------------------------------
module lrw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  lrw_pkg::lrw_status_t status,
    output lrw_pkg::lrw_cmd_t   cmd
);

    lrw_pkg::lrw_state_t state_reg, state_next;
    logic step_reg, step_next;
    logic phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrw_pkg::ST_IDLE;
            step_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        cmd        = '0;
        in_stall   = (state_reg != lrw_pkg::ST_IDLE);
        unique case (state_reg)
            lrw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == lrw_pkg::OP_STEP)
                    begin
                        cmd.mul    = 1'b1;
                        cmd.step   = 1'b1;
                        step_next  = 1'b1;
                        state_next = lrw_pkg::ST_ACC;
                    end
                    else
                    begin
                        cmd.load_seed = 1'b1;
                        step_next     = 1'b0;
                        phase_next    = 1'b0;
                        state_next    = lrw_pkg::ST_MUL;
                    end
                end
            end
            lrw_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                cmd.step   = step_reg;
                state_next = lrw_pkg::ST_ACC;
            end
            lrw_pkg::ST_ACC:
            begin
                cmd.acc  = 1'b1;
                cmd.step = step_reg;
                if (!step_reg && !phase_reg)
                begin
                    phase_next = 1'b1;
                    state_next = lrw_pkg::ST_ADD;
                end
                else if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = lrw_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = lrw_pkg::ST_EMIT;
                end
            end
            lrw_pkg::ST_ADD:
            begin
                cmd.add_seed = 1'b1;
                state_next   = lrw_pkg::ST_MUL;
            end
            lrw_pkg::ST_EMIT:
            begin
                cmd.step = step_reg;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = lrw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/lrw_datapath.sv @@
// ----------------------------------------------------------------------------
// lrw_datapath
// Generator state, split LCG multiplier, walker position and output register.
// ----------------------------------------------------------------------------
module lrw_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lrw_pkg::lrw_cmd_t                     cmd,
    output lrw_pkg::lrw_status_t                  status,
    input  logic [lrw_pkg::WORD_WIDTH-1:0]        seed_state,
    input  logic [lrw_pkg::WORD_WIDTH-1:0]        seed_sequence,
    input  logic                                  cfg_valid,
    input  logic [lrw_pkg::TIME_WIDTH-1:0]        cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [31:0]                    x_coord,
    output logic signed [31:0]                    y_coord,
    output logic [lrw_pkg::TIME_WIDTH-1:0]        elapsed_time,
    output logic                                  at_target,
    output logic [1:0]                            direction,
    output logic [lrw_pkg::WORD_WIDTH-1:0]        random_word
);

    localparam int CW = lrw_pkg::COORD_WIDTH;
    localparam int WW = lrw_pkg::WORD_WIDTH;
    localparam int SW = lrw_pkg::STATE_WIDTH;
    localparam int TW = lrw_pkg::TIME_WIDTH;

    logic [SW-1:0] lcg_state_reg, lcg_state_next;
    logic [SW-1:0] inc_reg, inc_next;
    logic [CW-1:0] x_reg, x_next;
    logic [CW-1:0] y_reg, y_next;
    logic [TW-1:0] time_reg, time_next;
    logic [TW-1:0] target_reg, target_next;
    logic          out_valid_reg, out_valid_next;

    logic [WW-1:0] seed_reg, seed_next;
    logic [SW-1:0] p0_reg, p0_next;
    logic [WW-1:0] p1_reg, p1_next;
    logic [WW-1:0] p2_reg, p2_next;
    logic [WW-1:0] word_reg, word_next;

    logic signed [31:0] xo_reg, xo_next;
    logic signed [31:0] yo_reg, yo_next;
    logic [TW-1:0]      to_reg, to_next;
    logic               hit_reg, hit_next;
    logic [1:0]         dir_reg, dir_next;
    logic [WW-1:0]      wo_reg, wo_next;

    logic [WW-1:0]   mixed;
    logic [4:0]      rot;
    logic [2*WW-1:0] rot_dbl;
    logic [SW-1:0]   x_ext, y_ext;
    lrw_pkg::lrw_dir_t dir;

    assign mixed   = WW'(((lcg_state_reg >> 18) ^ lcg_state_reg) >> 27);
    assign rot     = lcg_state_reg[63:59];
    assign rot_dbl = {mixed, mixed} >> rot;
    assign dir     = lrw_pkg::lrw_dir_t'(word_reg[WW-1 -: 2]);

    assign x_ext = SW'(signed'(x_next));
    assign y_ext = SW'(signed'(y_next));

    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_state_reg <= '0;
            inc_reg       <= SW'(1);
            x_reg         <= '0;
            y_reg         <= '0;
            time_reg      <= '0;
            target_reg    <= lrw_pkg::TARGET_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lcg_state_reg <= lcg_state_next;
            inc_reg       <= inc_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            time_reg      <= time_next;
            target_reg    <= target_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg <= seed_next;
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        word_reg <= word_next;
        xo_reg   <= xo_next;
        yo_reg   <= yo_next;
        to_reg   <= to_next;
        hit_reg  <= hit_next;
        dir_reg  <= dir_next;
        wo_reg   <= wo_next;
    end

    always_comb
    begin
        lcg_state_next = lcg_state_reg;
        inc_next       = inc_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        time_next      = time_reg;
        target_next    = target_reg;
        seed_next      = seed_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        word_next      = word_reg;

        if (cfg_valid)
        begin
            target_next = cfg_data;
        end

        if (cmd.load_seed)
        begin
            lcg_state_next = '0;
            inc_next       = {(SW-WW-1)'(0), seed_sequence, 1'b1};
            seed_next      = seed_state;
            x_next         = '0;
            y_next         = '0;
            time_next      = '0;
        end

        if (cmd.mul)
        begin
            p0_next   = {WW'(0), lcg_state_reg[WW-1:0]} * {WW'(0), lrw_pkg::LCG_MULT_LO};
            p1_next   = lcg_state_reg[WW-1:0] * lrw_pkg::LCG_MULT_HI;
            p2_next   = lcg_state_reg[SW-1:WW] * lrw_pkg::LCG_MULT_LO;
            word_next = rot_dbl[WW-1:0];
        end

        if (cmd.acc)
        begin
            lcg_state_next = p0_reg + {p1_reg + p2_reg, WW'(0)} + {inc_reg[SW-1:1], 1'b1};
            if (cmd.step)
            begin
                unique case (dir)
                    lrw_pkg::DIR_POS_X: x_next = x_reg + CW'(1);
                    lrw_pkg::DIR_NEG_X: x_next = x_reg - CW'(1);
                    lrw_pkg::DIR_POS_Y: y_next = y_reg + CW'(1);
                    lrw_pkg::DIR_NEG_Y: y_next = y_reg - CW'(1);
                    default:            x_next = x_reg;
                endcase
                if (time_reg != lrw_pkg::TIME_MAX)
                begin
                    time_next = time_reg + TW'(1);
                end
            end
        end

        if (cmd.add_seed)
        begin
            lcg_state_next = lcg_state_reg + {WW'(0), seed_reg};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        xo_next        = xo_reg;
        yo_next        = yo_reg;
        to_next        = to_reg;
        hit_next       = hit_reg;
        dir_next       = dir_reg;
        wo_next        = wo_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            xo_next        = x_ext[31:0];
            yo_next        = y_ext[31:0];
            to_next        = time_next;
            hit_next       = cmd.step && (time_next == target_reg);
            dir_next       = cmd.step ? word_reg[WW-1 -: 2] : 2'(lrw_pkg::DIR_POS_X);
            wo_next        = cmd.step ? word_reg : '0;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign x_coord      = xo_reg;
    assign y_coord      = yo_reg;
    assign elapsed_time = to_reg;
    assign at_target    = hit_reg;
    assign direction    = dir_reg;
    assign random_word  = wo_reg;

endmodule

@@ hw/rtl/lattice_random_walk_pcg32.sv @@
// ----------------------------------------------------------------------------
// lattice_random_walk_pcg32
// 2D unit-step lattice random walk driven by a PCG32 XSH-RR generator.
// ----------------------------------------------------------------------------
// One item is worked at a time. In a step beat the 64-bit LCG multiply by its
// constant is split into three 32x32 partial products registered in ST_IDLE
// and summed with the increment in ST_ACC. A start beat passes ST_MUL, ST_ACC,
// ST_ADD, ST_MUL and ST_ACC (two generator advances plus the seed add). The
// result sits in an output register, so a new beat is taken while the
// previous result is still stalled downstream. target_time is written through
// the cfg port, which is always ready.
module lattice_random_walk_pcg32 (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  operation,
    input  logic [lrw_pkg::WORD_WIDTH-1:0]        seed_state,
    input  logic [lrw_pkg::WORD_WIDTH-1:0]        seed_sequence,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [31:0]                    x_coord,
    output logic signed [31:0]                    y_coord,
    output logic [lrw_pkg::TIME_WIDTH-1:0]        elapsed_time,
    output logic                                  at_target,
    output logic [1:0]                            direction,
    output logic [lrw_pkg::WORD_WIDTH-1:0]        random_word,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lrw_pkg::TIME_WIDTH-1:0]        cfg_data
);

    lrw_pkg::lrw_cmd_t    cmd;
    lrw_pkg::lrw_status_t status;

    assign cfg_ready = 1'b1;

    lrw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .status    (status),
        .cmd       (cmd)
    );

    lrw_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .seed_state    (seed_state),
        .seed_sequence (seed_sequence),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .elapsed_time  (elapsed_time),
        .at_target     (at_target),
        .direction     (direction),
        .random_word   (random_word)
    );

endmodule

@@ hw/rtl/lrw_checker.sv @@
// ----------------------------------------------------------------------------
// lrw_checker
// Port-level assertions for the lattice walk, bound to the top level.
// ----------------------------------------------------------------------------
`include "lattice_random_walk_pcg32_macros.svh"

module lrw_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic signed [31:0]                    x_coord,
    input logic signed [31:0]                    y_coord,
    input logic [lrw_pkg::TIME_WIDTH-1:0]        elapsed_time,
    input logic                                  at_target,
    input logic [1:0]                            direction,
    input logic [lrw_pkg::WORD_WIDTH-1:0]        random_word
);

    logic [32+32+lrw_pkg::TIME_WIDTH+1+2+lrw_pkg::WORD_WIDTH-1:0] payload;
    logic                                                         start_clear;

    assign payload     = {x_coord, y_coord, elapsed_time, at_target, direction, random_word};
    assign start_clear = !at_target && (direction == lrw_pkg::DIR_POS_X) &&
                         (random_word == '0) && (x_coord == '0) && (y_coord == '0);

    `LRW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `LRW_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(payload))
    `LRW_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)
    `LRW_ASSERT_CLK(a_start_beat, (out_valid && elapsed_time == '0) |-> start_clear)

endmodule

bind lattice_random_walk_pcg32 lrw_checker u_lrw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .elapsed_time (elapsed_time),
    .at_target    (at_target),
    .direction    (direction),
    .random_word  (random_word)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PCG32-driven 2D lattice random walk. A directed
// table (reset generator, seed extremes, start results) is followed by random
// start/step runs under several target_time settings. Every result beat is
// checked against its typed table entry or an in-bench walk predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import lrw_pkg::*;

    localparam logic [63:0] PCG_MULT       = 64'd6364136223846793005;
    localparam int          SETTLE_CYCLES  = 20;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          PHASE_ITEMS    = 250;
    localparam int          NUM_PHASES     = 7;

    typedef struct packed {
        logic signed [31:0]    x_pos;
        logic signed [31:0]    y_pos;
        logic [TIME_WIDTH-1:0] steps;
        logic                  hit;
        lrw_dir_t              dir;
        logic [31:0]           word;
    } walk_result_t;

    typedef struct packed {
        logic         op;
        logic [31:0]  seed_st;
        logic [31:0]  seed_seq;
        logic         typed;
        walk_result_t res;
    } walk_row_t;

    localparam walk_result_t AT_ORIGIN = '{32'sd0, 32'sd0, 31'd0, 1'b0, DIR_POS_X, 32'd0};

    // typed rows: reset generator draws 0 twice, start always lands at the origin
    walk_row_t directed_rows [24] = '{
        '{OP_STEP,  32'h0000_0000, 32'h0000_0000, 1'b1,
          '{32'sd1, 32'sd0, 31'd1, 1'b1, DIR_POS_X, 32'd0}},
        '{OP_STEP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{32'sd2, 32'sd0, 31'd2, 1'b0, DIR_POS_X, 32'd0}},
        '{OP_STEP,  32'h1234_5678, 32'h9ABC_DEF0, 1'b0, AT_ORIGIN},
        '{OP_START, 32'h0000_0000, 32'h0000_0000, 1'b1, AT_ORIGIN},
        '{OP_STEP,  32'h0000_0000, 32'h0000_0000, 1'b0, AT_ORIGIN},
        '{OP_STEP,  32'h0000_0000, 32'h0000_0000, 1'b0, AT_ORIGIN},
        '{OP_STEP,  32'h0000_0000, 32'h0000_0000, 1'b0, AT_ORIGIN},
        '{OP_STEP,  32'h0000_0000, 32'h0000_0000, 1'b0, AT_ORIGIN},
        '{OP_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, AT_ORIGIN},
        '{OP_STEP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, AT_ORIGIN},
        '{OP_STEP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, AT_ORIGIN},
        '{OP_STEP,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, AT_ORIGIN},
        '{OP_STEP,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, AT_ORIGIN},
        '{OP_STEP,  32'h5555_5555, 32'hAAAA_AAAA, 1'b0, AT_ORIGIN},
        '{OP_START, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, AT_ORIGIN},
        '{OP_STEP,  32'h0000_0000, 32'h0000_0000, 1'b0, AT_ORIGIN},
        '{OP_STEP,  32'h0000_0000, 32'h0000_0000, 1'b0, AT_ORIGIN},
        '{OP_START, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, AT_ORIGIN},
        '{OP_STEP,  32'h0000_0000, 32'h0000_0000, 1'b0, AT_ORIGIN},
        '{OP_STEP,  32'h0000_0000, 32'h0000_0000, 1'b0, AT_ORIGIN},
        '{OP_START, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, AT_ORIGIN},
        '{OP_START, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, AT_ORIGIN},
        '{OP_STEP,  32'h0000_0000, 32'h0000_0000, 1'b0, AT_ORIGIN},
        '{OP_STEP,  32'h0000_0000, 32'h0000_0000, 1'b0, AT_ORIGIN}
    };

    localparam logic [TIME_WIDTH-1:0] PHASE_TARGETS [NUM_PHASES] = '{
        TIME_MAX, 31'd0, 31'd1, 31'd12, 31'd30, 31'd5, 31'd20
    };

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    operation;
    logic [WORD_WIDTH-1:0]   seed_state;
    logic [WORD_WIDTH-1:0]   seed_sequence;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [31:0]      x_coord;
    logic signed [31:0]      y_coord;
    logic [TIME_WIDTH-1:0]   elapsed_time;
    logic                    at_target;
    logic [1:0]              direction;
    logic [WORD_WIDTH-1:0]   random_word;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [TIME_WIDTH-1:0]   cfg_data;

    // predictor state
    logic [63:0]             lcg_st;
    logic [63:0]             lcg_inc;
    logic signed [31:0]      walk_x;
    logic signed [31:0]      walk_y;
    logic [TIME_WIDTH-1:0]   walk_time;
    logic [TIME_WIDTH-1:0]   walk_target;

    walk_result_t            pending_positions [$];
    walk_result_t            head_result;
    bit                      idle_on = 1'b1;
    int                      err_count = 0;
    int                      items_sent = 0;
    int                      stall_left = 0;
    int                      quiet_cycles = 0;

    lattice_random_walk_pcg32 uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .seed_state    (seed_state),
        .seed_sequence (seed_sequence),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .elapsed_time  (elapsed_time),
        .at_target     (at_target),
        .direction     (direction),
        .random_word   (random_word),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // XSH-RR output from the old state, then one LCG advance
    function automatic logic [31:0] pcg_next_word();
        logic [63:0] old;
        logic [31:0] mixed;
        logic [63:0] rotated;
        old = lcg_st;
        lcg_st = old * PCG_MULT + (lcg_inc | 64'd1);
        mixed = 32'(((old >> 18) ^ old) >> 27);
        rotated = {mixed, mixed} >> old[63:59];
        return rotated[31:0];
    endfunction

    function automatic walk_result_t advance_walk(input logic op, input logic [31:0] ss,
                                                  input logic [31:0] sq);
        walk_result_t res;
        logic [31:0]  word;
        res = AT_ORIGIN;
        if (op == OP_START)
        begin
            lcg_st = 64'd0;
            lcg_inc = {31'd0, sq, 1'b1};
            void'(pcg_next_word());
            lcg_st = lcg_st + {32'd0, ss};
            void'(pcg_next_word());
            walk_x = 32'sd0;
            walk_y = 32'sd0;
            walk_time = '0;
        end
        else
        begin
            word = pcg_next_word();
            res.dir = lrw_dir_t'(word[31:30]);
            res.word = word;
            case (res.dir)
                DIR_POS_X: walk_x = walk_x + 32'sd1;
                DIR_NEG_X: walk_x = walk_x - 32'sd1;
                DIR_POS_Y: walk_y = walk_y + 32'sd1;
                default:   walk_y = walk_y - 32'sd1;
            endcase
            if (walk_time != TIME_MAX)
                walk_time = walk_time + 31'd1;
            res.hit = (walk_time == walk_target);
        end
        res.x_pos = walk_x;
        res.y_pos = walk_y;
        res.steps = walk_time;
        return res;
    endfunction

    function automatic logic [31:0] rand_seed();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_walk_item(input logic op, input logic [31:0] ss,
                                  input logic [31:0] sq, input logic typed,
                                  input walk_result_t typed_res);
        walk_result_t res;
        int           gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        seed_state    <= ss;
        seed_sequence <= sq;
        do @(posedge clk); while (in_stall);
        res = advance_walk(op, ss, sq);
        pending_positions.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    task automatic send_steps(input int count);
        repeat (count) send_walk_item(OP_STEP, $urandom(), $urandom(), 1'b0, AT_ORIGIN);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_target(input logic [TIME_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        walk_target = value;
    endtask

    initial
    begin
        int phase_end;
        int run_len;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_STEP;
        seed_state    = '0;
        seed_sequence = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        lcg_st        = 64'd0;
        lcg_inc       = 64'd1;
        walk_x        = 32'sd0;
        walk_y        = 32'sd0;
        walk_time     = '0;
        walk_target   = TARGET_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_walk_item(directed_rows[i].op, directed_rows[i].seed_st,
                           directed_rows[i].seed_seq, directed_rows[i].typed,
                           directed_rows[i].res);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            write_target(PHASE_TARGETS[p]);
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200)
                                                        : $urandom_range(1, 40);
                case ($urandom_range(0, 9))
                    8: send_steps($urandom_range(1, 10));
                    9:
                    begin
                        send_walk_item(OP_START, rand_seed(), rand_seed(), 1'b0, AT_ORIGIN);
                        send_walk_item(OP_START, rand_seed(), rand_seed(), 1'b0, AT_ORIGIN);
                    end
                    default:
                    begin
                        send_walk_item(OP_START, rand_seed(), rand_seed(), 1'b0, AT_ORIGIN);
                        send_steps(run_len);
                    end
                endcase
            end
        end

        drain_results();
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_positions.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    err_count++;
                end
                else
                begin
                    head_result = pending_positions.pop_front();
                    if (x_coord !== head_result.x_pos)
                    begin
                        $error("x_coord: expected %0d, got %0d", head_result.x_pos, x_coord);
                        err_count++;
                    end
                    if (y_coord !== head_result.y_pos)
                    begin
                        $error("y_coord: expected %0d, got %0d", head_result.y_pos, y_coord);
                        err_count++;
                    end
                    if (elapsed_time !== head_result.steps)
                    begin
                        $error("elapsed_time: expected %0d, got %0d", head_result.steps,
                               elapsed_time);
                        err_count++;
                    end
                    if (at_target !== head_result.hit)
                    begin
                        $error("at_target: expected %0b, got %0b", head_result.hit, at_target);
                        err_count++;
                    end
                    if (direction !== head_result.dir)
                    begin
                        $error("direction: expected %0d, got %0d", head_result.dir, direction);
                        err_count++;
                    end
                    if (random_word !== head_result.word)
                    begin
                        $error("random_word: expected %h, got %h", head_result.word, random_word);
                        err_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left <= $urandom_range(0, 10);
                out_stall  <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lrw_pkg.sv
hw/rtl/lrw_ctrl.sv
hw/rtl/lrw_datapath.sv
hw/rtl/lattice_random_walk_pcg32.sv
hw/rtl/lrw_checker.sv
tb/sv/tb_top.sv
